### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the binomial heap.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/bmh_pkg.sv
// Shared types and constants of the binomial min heap.
// No dependencies; imported by binomial_min_heap and its testbench.
package bmh_pkg;

  localparam int MAX_ORDER = 12;
  localparam int NODE_W    = MAX_ORDER;
  localparam int NODES     = 1 << MAX_ORDER;
  localparam int ORD_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int KEY_W     = 32;
  localparam int COUNT_W   = 12;

  typedef logic [1:0] op_t;
  localparam op_t OP_INSERT  = 2'd0;
  localparam op_t OP_FIND    = 2'd1;
  localparam op_t OP_EXTRACT = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    op_t                      operation;
    logic signed [KEY_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  min_value;
    status_t                  status;
    logic [COUNT_W-1:0]       element_count;
  } rsp_t;

  // Node memory entry: key and first child pointer.
  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic [NODE_W-1:0]        child;
  } node_t;

endpackage

### hw/rtl/binomial_min_heap.sv
// Binomial min heap top level: control sequencer, root table, node memories.
// Depends on bmh_pkg, bmh_ram and assert_macros.svh.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | input     | in_valid/in_ready  | in_data  (operation, value)
//  out     | output    | out_valid/out_ready| out_data (min_value, status, count)
//
// One transaction at a time. Find, unknown and rejected requests go straight to the
// result. Insert takes a node (popping the free list when one was released), writes it,
// carries it through the orders with a link at each occupied one, then scans the roots
// for the minimum; extract reads the removed root's children, merges them order by order
// into the roots and scans likewise. No clearing pass after reset. A pending result
// holds in the output register while the next transaction runs; that one stalls at its end.
module binomial_min_heap (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bmh_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bmh_pkg::rsp_t out_data
);
  import bmh_pkg::*;
  `include "assert_macros.svh"

  localparam logic [ORD_W-1:0]     LAST_ORD = ORD_W'(MAX_ORDER - 1);
  localparam logic [MAX_ORDER-1:0] CAPACITY = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_ALLOC_CAP, S_INS_WR, S_INS_STEP, S_LK_WR,
    S_EX_RD, S_EX_CAP, S_WK_RD, S_WK_CAP, S_FREE, S_MRG, S_SCAN, S_DONE
  } state_t;

  state_t                  state;
  logic signed [KEY_W-1:0] val;
  logic [ORD_W-1:0]        ord;
  logic [ORD_W-1:0]        wj;
  logic [ORD_W-1:0]        xm;
  logic [NODE_W-1:0]       xr;
  logic [NODE_W-1:0]       walk;
  logic [NODE_W-1:0]       carry_idx;
  logic signed [KEY_W-1:0] carry_key;
  logic                    carry_ok;
  logic [NODE_W-1:0]       lk_top;
  logic signed [KEY_W-1:0] lk_top_key;
  logic [NODE_W-1:0]       lk_sub;
  logic                    lk_ins;
  logic [MAX_ORDER-1:0]    root_valid;
  logic [NODE_W-1:0]       root_idx [MAX_ORDER];
  logic signed [KEY_W-1:0] root_key [MAX_ORDER];
  logic [NODE_W-1:0]       kid_idx  [MAX_ORDER];
  logic signed [KEY_W-1:0] kid_key  [MAX_ORDER];
  logic [ORD_W-1:0]        min_order;
  logic signed [KEY_W-1:0] min_key;
  logic [NODE_W-1:0]       min_idx;
  logic                    found;
  logic [MAX_ORDER-1:0]    cnt;
  logic [NODE_W:0]         fresh;
  logic [NODE_W:0]         free_cnt;
  logic [NODE_W-1:0]       free_head;
  logic signed [KEY_W-1:0] res_minv;
  status_t                 res_status;

  // Memory ports
  logic              a_we, b_we;
  logic [NODE_W-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
  node_t             a_wdata, a_rdata;
  logic [NODE_W-1:0] b_wdata, b_rdata;

  // Link operand selection
  logic                    have_root, have_kid, two_or_more, three;
  logic [1:0]              n_trees;
  logic [NODE_W-1:0]       t0_idx, t1_idx, top_idx, sub_idx;
  logic signed [KEY_W-1:0] t0_key, t1_key, top_key;
  logic                    swap;

  assign in_ready = (state == S_IDLE);

  // Node key and first child
  bmh_ram #(.WIDTH($bits(node_t)), .DEPTH(NODES)) u_node_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  // Next sibling; doubles as the free list link of a released node
  bmh_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_sib_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  // Pick the two trees to link and drive the memory ports
  always_comb begin
    have_root   = root_valid[ord];
    have_kid    = (ord < xm);
    n_trees     = 2'(have_root) + 2'(have_kid) + 2'(carry_ok);
    two_or_more = (n_trees >= 2'd2);
    three       = (n_trees == 2'd3);
    if (state == S_INS_STEP) begin
      t0_idx = root_idx[ord];
      t0_key = root_key[ord];
      t1_idx = carry_idx;
      t1_key = carry_key;
    end else begin
      t0_idx = have_root ? root_idx[ord] : (have_kid ? kid_idx[ord] : carry_idx);
      t0_key = have_root ? root_key[ord] : (have_kid ? kid_key[ord] : carry_key);
      t1_idx = (have_root && have_kid) ? kid_idx[ord] : carry_idx;
      t1_key = (have_root && have_kid) ? kid_key[ord] : carry_key;
    end
    swap    = (t1_key < t0_key);
    top_idx = swap ? t1_idx : t0_idx;
    top_key = swap ? t1_key : t0_key;
    sub_idx = swap ? t0_idx : t1_idx;

    a_we    = 1'b0;
    a_waddr = '0;
    a_wdata = '0;
    a_raddr = '0;
    b_we    = 1'b0;
    b_waddr = '0;
    b_wdata = '0;
    b_raddr = '0;
    unique case (state)
      S_ALLOC: begin
        b_raddr = free_head;
      end
      S_INS_WR: begin
        a_we    = 1'b1;
        a_waddr = carry_idx;
        a_wdata = '{key: val, child: '0};
      end
      S_INS_STEP, S_MRG: begin
        a_raddr = top_idx;
      end
      S_LK_WR: begin
        a_we    = 1'b1;
        a_waddr = lk_top;
        a_wdata = '{key: lk_top_key, child: lk_sub};
        b_we    = 1'b1;
        b_waddr = lk_sub;
        b_wdata = a_rdata.child;
      end
      S_EX_RD: begin
        a_raddr = xr;
      end
      S_WK_RD: begin
        a_raddr = walk;
        b_raddr = walk;
      end
      S_FREE: begin
        b_we    = 1'b1;
        b_waddr = xr;
        b_wdata = free_head;
      end
      default: ;
    endcase
  end

  // Sequencer, root table and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      root_valid <= '0;
      cnt        <= '0;
      fresh      <= '0;
      free_cnt   <= '0;
      carry_ok   <= 1'b0;
      min_order  <= '0;
      out_valid  <= 1'b0;
    end else begin
      // S_DONE loads the register itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            val <= in_data.value;
            case (in_data.operation)
              OP_INSERT: begin
                res_minv <= '0;
                if (cnt == CAPACITY) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  if (free_cnt != '0) begin
                    state <= S_ALLOC;
                  end else begin
                    carry_idx <= fresh[NODE_W-1:0];
                    fresh     <= fresh + 1'b1;
                    state     <= S_INS_WR;
                  end
                end
              end
              OP_FIND, OP_EXTRACT: begin
                if (cnt == '0) begin
                  res_minv   <= '0;
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  res_minv   <= min_key;
                  res_status <= ST_OK;
                  if (in_data.operation == OP_EXTRACT) begin
                    xm                    <= min_order;
                    xr                    <= min_idx;
                    root_valid[min_order] <= 1'b0;
                    state                 <= S_EX_RD;
                  end else begin
                    state <= S_DONE;
                  end
                end
              end
              default: begin
                res_minv   <= '0;
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        // pop the free list
        S_ALLOC: state <= S_ALLOC_CAP;
        S_ALLOC_CAP: begin
          carry_idx <= free_head;
          free_head <= b_rdata;
          free_cnt  <= free_cnt - 1'b1;
          state     <= S_INS_WR;
        end
        S_INS_WR: begin
          carry_key <= val;
          ord       <= '0;
          state     <= S_INS_STEP;
        end
        // binary carry through the orders
        S_INS_STEP: begin
          if (!root_valid[ord]) begin
            root_valid[ord] <= 1'b1;
            root_idx[ord]   <= carry_idx;
            root_key[ord]   <= carry_key;
            cnt             <= cnt + 1'b1;
            ord             <= '0;
            found           <= 1'b0;
            state           <= S_SCAN;
          end else begin
            root_valid[ord] <= 1'b0;
            lk_top          <= top_idx;
            lk_top_key      <= top_key;
            lk_sub          <= sub_idx;
            lk_ins          <= 1'b1;
            state           <= S_LK_WR;
          end
        end
        // finish a link: sub becomes first child of top
        S_LK_WR: begin
          carry_idx <= lk_top;
          carry_key <= lk_top_key;
          carry_ok  <= 1'b1;
          if (lk_ins) begin
            ord   <= ord + 1'b1;
            state <= S_INS_STEP;
          end else if (ord == LAST_ORD) begin
            ord   <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end else begin
            ord   <= ord + 1'b1;
            state <= S_MRG;
          end
        end
        // read the removed root's first child
        S_EX_RD: state <= S_EX_CAP;
        S_EX_CAP: begin
          walk <= a_rdata.child;
          if (xm == '0) begin
            state <= S_FREE;
          end else begin
            wj    <= xm - 1'b1;
            state <= S_WK_RD;
          end
        end
        // children come highest order first
        S_WK_RD: state <= S_WK_CAP;
        S_WK_CAP: begin
          kid_idx[wj] <= walk;
          kid_key[wj] <= a_rdata.key;
          walk        <= b_rdata;
          if (wj == '0) begin
            state <= S_FREE;
          end else begin
            wj    <= wj - 1'b1;
            state <= S_WK_RD;
          end
        end
        S_FREE: begin
          free_head <= xr;
          free_cnt  <= free_cnt + 1'b1;
          cnt       <= cnt - 1'b1;
          carry_ok  <= 1'b0;
          ord       <= '0;
          state     <= S_MRG;
        end
        // merge root, child and carry of one order
        S_MRG: begin
          root_valid[ord] <= (n_trees == 2'd1) || three;
          carry_ok        <= 1'b0;
          if (n_trees == 2'd1) begin
            root_idx[ord] <= t0_idx;
            root_key[ord] <= t0_key;
          end else if (three) begin
            root_idx[ord] <= carry_idx;
            root_key[ord] <= carry_key;
          end
          if (two_or_more) begin
            lk_top     <= top_idx;
            lk_top_key <= top_key;
            lk_sub     <= sub_idx;
            lk_ins     <= 1'b0;
            state      <= S_LK_WR;
          end else if (ord == LAST_ORD) begin
            ord   <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end else begin
            ord <= ord + 1'b1;
          end
        end
        // lowest order wins ties
        S_SCAN: begin
          if (root_valid[ord] && (!found || root_key[ord] < min_key)) begin
            min_key   <= root_key[ord];
            min_idx   <= root_idx[ord];
            min_order <= ord;
            found     <= 1'b1;
          end
          if (ord == LAST_ORD) begin
            state <= S_DONE;
          end else begin
            ord <= ord + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_data.min_value     <= res_minv;
            out_data.status        <= res_status;
            out_data.element_count <= COUNT_W'(cnt);
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Binomial forest shape matches the key count
  `ASSERT_IMPLY(a_shape, clk, rst, state == S_IDLE, root_valid == cnt)
  // Every node is either held or on the free list
  `ASSERT_IMPLY(a_nodes, clk, rst, state == S_IDLE, ({1'b0, cnt} == (fresh - free_cnt)))
  // The cached minimum points at a live root
  `ASSERT_IMPLY(a_min, clk, rst, (state == S_IDLE) && (cnt != '0), root_valid[min_order])
  // An accepted transaction leaves the idle state
  `ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready)

endmodule

### hw/rtl/bmh_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; instantiated by binomial_min_heap.
module bmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### verif/binomial_min_heap_tb.sv
// Self-checking bench for binomial_min_heap: directed table, hold-off, random mix.
// Depends on bmh_pkg; results are checked against a binomial-forest predictor.
module binomial_min_heap_tb;
  import bmh_pkg::*;

  localparam int CAP = NODES - 1;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  req_t  in_data;
  logic  out_valid;
  logic  out_ready;
  rsp_t  out_data;

  binomial_min_heap dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state: forest of node indexes
  logic signed [KEY_W-1:0] heap_key [NODES];
  int heap_child [NODES];
  int heap_sib [NODES];
  int order_root [MAX_ORDER];
  bit order_used [MAX_ORDER];
  int free_stack [NODES];
  int free_top;
  int min_order;
  int key_total;

  rsp_t pending_rsp[$];
  int   mismatches;
  int   rsp_seen;
  int   sent;
  bit   hold_off;
  int   n_empty, n_full;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int join_trees(int a, int b);
    int top;
    int sub;
    top = a;
    sub = b;
    if (heap_key[sub] < heap_key[top]) begin
      top = b;
      sub = a;
    end
    heap_sib[sub] = heap_child[top];
    heap_child[top] = sub;
    return top;
  endfunction

  function automatic void locate_min();
    bit found;
    found = 0;
    min_order = 0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (order_used[i] && (!found || heap_key[order_root[i]] < heap_key[order_root[min_order]])) begin
        min_order = i;
        found = 1;
      end
    end
  endfunction

  function automatic void heap_clear();
    for (int i = 0; i < MAX_ORDER; i++) order_used[i] = 0;
    for (int i = 0; i < NODES; i++) free_stack[i] = i;
    free_top = NODES;
    min_order = 0;
    key_total = 0;
  endfunction

  // Apply one transaction to the predictor and return its expected result
  function automatic rsp_t heap_apply(req_t r);
    rsp_t res;
    int carry;
    int m;
    int rt;
    int c;
    int kids [MAX_ORDER];
    bit carry_ok;
    int t [3];
    int n;
    res = '0;
    if (r.operation == OP_INSERT) begin
      if (key_total >= CAP || free_top == 0) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        free_top--;
        carry = free_stack[free_top];
        heap_key[carry] = r.value;
        heap_child[carry] = 0;
        heap_sib[carry] = 0;
        for (int i = 0; i < MAX_ORDER; i++) begin
          if (!order_used[i]) begin
            order_root[i] = carry;
            order_used[i] = 1;
            break;
          end
          carry = join_trees(order_root[i], carry);
          order_used[i] = 0;
        end
        key_total++;
        locate_min();
      end
    end else if (r.operation == OP_FIND || r.operation == OP_EXTRACT) begin
      if (key_total == 0) begin
        res.status = ST_EMPTY;
        n_empty++;
      end else begin
        m = min_order;
        rt = order_root[m];
        res.min_value = heap_key[rt];
        if (r.operation == OP_EXTRACT) begin
          c = heap_child[rt];
          carry = 0;
          carry_ok = 0;
          order_used[m] = 0;
          if (free_top < NODES) begin
            free_stack[free_top] = rt;
            free_top++;
          end
          for (int j = m - 1; j >= 0; j--) begin
            kids[j] = c;
            c = heap_sib[c];
          end
          for (int j = 0; j < MAX_ORDER; j++) begin
            n = 0;
            if (order_used[j]) begin t[n] = order_root[j]; n++; end
            if (j < m) begin t[n] = kids[j]; n++; end
            if (carry_ok) begin t[n] = carry; n++; end
            carry_ok = 0;
            order_used[j] = 0;
            if (n == 1) begin
              order_root[j] = t[0];
              order_used[j] = 1;
            end else if (n >= 2) begin
              carry = join_trees(t[0], t[1]);
              carry_ok = 1;
              if (n == 3) begin
                order_root[j] = t[2];
                order_used[j] = 1;
              end
            end
          end
          key_total--;
          locate_min();
        end
      end
    end
    res.element_count = key_total[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("t=%0t result %0d: %s got %0h want %0h", $time, rsp_seen, what, got, want);
    mismatches++;
  endtask

  // Send one transaction; an optional typed expectation is cross-checked
  task automatic send_req(op_t op, logic signed [KEY_W-1:0] val, bit idle,
                          bit has_want, rsp_t want);
    req_t r;
    rsp_t p;
    if (idle) begin
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    r.operation = op;
    r.value = val;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = heap_apply(r);
    if (has_want) begin
      if (p.min_value !== want.min_value)
        report_mismatch("directed min_value", p.min_value, want.min_value);
      if (p.status !== want.status)
        report_mismatch("directed status", 32'(p.status), 32'(want.status));
      if (p.element_count !== want.element_count)
        report_mismatch("directed element_count", 32'(p.element_count),
                        32'(want.element_count));
    end
    pending_rsp = {pending_rsp, p};
    sent++;
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off
  initial begin
    int cyc;
    int hold_left;
    bit held;
    cyc = 0;
    hold_left = 0;
    held = 0;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_off && !held) begin
        hold_left = 400;
        held = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (cyc > 20000 && cyc < 30000) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 27);
    end
  end

  // Result check
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result", out_data.min_value, 32'd0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_data.min_value !== want.min_value)
          report_mismatch("min_value", out_data.min_value, want.min_value);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.element_count !== want.element_count)
          report_mismatch("element_count", 32'(out_data.element_count),
                          32'(want.element_count));
      end
      rsp_seen++;
    end
  end

  typedef struct {
    op_t                     op;
    logic signed [KEY_W-1:0] val;
    bit                      typed;
    rsp_t                    want;
  } row_t;

  row_t dir_rows [$];

  function automatic row_t mk(op_t op, int val, bit typed, logic [31:0] mv, status_t st, int cnt);
    row_t r;
    r.op = op;
    r.val = val;
    r.typed = typed;
    r.want.min_value = mv;
    r.want.status = st;
    r.want.element_count = COUNT_W'(cnt);
    return r;
  endfunction

  function automatic void add_row(row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  initial begin
    int w;
    int pick;
    bit idle_on;
    mismatches = 0;
    rsp_seen = 0;
    sent = 0;
    hold_off = 0;
    n_empty = 0;
    n_full = 0;
    heap_clear();
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: empty heap, extremes, ties, unknown operation
    add_row(mk(OP_FIND, 0, 1, 0, ST_EMPTY, 0));
    add_row(mk(OP_EXTRACT, 0, 1, 0, ST_EMPTY, 0));
    add_row(mk(OP_INSERT, 32'h7fffffff, 1, 0, ST_OK, 1));
    add_row(mk(OP_FIND, 0, 1, 32'h7fffffff, ST_OK, 1));
    add_row(mk(OP_INSERT, 32'h80000000, 1, 0, ST_OK, 2));
    add_row(mk(OP_FIND, 0, 1, 32'h80000000, ST_OK, 2));
    add_row(mk(2'd3, -1, 1, 0, ST_OK, 2));
    add_row(mk(OP_INSERT, 5, 0, 0, ST_OK, 0));
    add_row(mk(OP_INSERT, 5, 0, 0, ST_OK, 0));
    add_row(mk(OP_INSERT, -1, 0, 0, ST_OK, 0));
    add_row(mk(OP_INSERT, 0, 0, 0, ST_OK, 0));
    add_row(mk(OP_EXTRACT, 0, 1, 32'h80000000, ST_OK, 5));
    add_row(mk(OP_EXTRACT, 0, 0, 0, ST_OK, 0));
    add_row(mk(OP_EXTRACT, 0, 0, 0, ST_OK, 0));
    add_row(mk(OP_EXTRACT, 0, 0, 0, ST_OK, 0));
    add_row(mk(OP_EXTRACT, 0, 0, 0, ST_OK, 0));
    add_row(mk(OP_EXTRACT, 0, 1, 32'h7fffffff, ST_OK, 0));
    add_row(mk(OP_EXTRACT, 0, 1, 0, ST_EMPTY, 0));
    foreach (dir_rows[i])
      send_req(dir_rows[i].op, dir_rows[i].val, 1, dir_rows[i].typed, dir_rows[i].want);

    // Long hold-off on the receiver while inserts keep coming
    hold_off = 1;
    repeat (12) send_req(OP_INSERT, $urandom, 0, 0, '0);
    hold_off = 0;

    // Random mix, drifting between fill and drain phases; one stretch sent gap-free
    for (int k = 0; k < 1600; k++) begin
      w = (k / 200) % 2 ? 30 : 65;
      idle_on = !(k >= 700 && k < 900);
      pick = $urandom_range(99);
      if (pick < 3) send_req(2'd3, $urandom, idle_on, 0, '0);
      else if (pick < 3 + w) begin
        if ($urandom_range(3) == 0)
          send_req(OP_INSERT, $urandom_range(7) - 4, idle_on, 0, '0);
        else send_req(OP_INSERT, $urandom, idle_on, 0, '0);
      end else if (pick < 15 + w) send_req(OP_FIND, $urandom, idle_on, 0, '0);
      else send_req(OP_EXTRACT, $urandom, idle_on, 0, '0);
    end

    // Drain a little at the end
    repeat (20) send_req(OP_EXTRACT, 0, 1, 0, '0);
    send_req(OP_FIND, 0, 1, 0, '0);
    in_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results", sent, rsp_seen);
    $display("Empty-heap results %0d, full-heap drops %0d", n_empty, n_full);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### binomial_min_heap.f
+incdir+hw/rtl
hw/rtl/bmh_pkg.sv
hw/rtl/bmh_ram.sv
hw/rtl/binomial_min_heap.sv
verif/binomial_min_heap_tb.sv
